// File: rtl/edfs_pkg.sv
// shared types and codes for the rm / edf tick scheduler
package edfs_pkg;

   // request kinds
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_POLICY = 2'd0;
   localparam logic [1:0] CSR_ACTIVE = 2'd1;

   // policy codes
   localparam logic POLICY_RM  = 1'b0;
   localparam logic POLICY_EDF = 1'b1;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  task_index;
      logic [15:0] period;
      logic [15:0] exec_time;
      logic [15:0] rel_deadline;
   } sched_req_type;

   typedef struct packed {
      logic [1:0]  done_kind;
      logic [4:0]  running_task;
      logic [31:0] tick_time;
      logic        job_finished;
   } sched_rsp_type;

   // one task entry as held in the task memory
   typedef struct packed {
      logic [15:0] period;
      logic [15:0] exec_time;
      logic [15:0] rel_deadline;
      logic [15:0] work_left;
      logic [31:0] release_time;
   } task_entry_type;

endpackage

// File: rtl/rm_edf_tick_scheduler.sv
// rate monotonic / earliest deadline first tick scheduler, top level
//
//   channel  ports                               direction  handshake
//   request  start, busy, req_payload            in         start & !busy
//   response rsp_valid, rsp_payload              out        one-cycle strobe
//   csr      csr_valid, csr_ready, csr_index,    in         valid & ready
//            csr_wdata
//
// load, restart and unknown requests answer in the cycle after the transfer and
// leave busy low, so a new request may follow at once.
// a tick scans the active task entries through the task memory, one read per
// cycle through a registered read port, then writes the chosen entry back.
// reset clears time, selects rm, sets the active count to 1 and marks every
// entry fresh (work reloads, release time zero); no clearing pass is needed.
// the receiver cannot stall; each response is shown for one cycle only.
module rm_edf_tick_scheduler
   import edfs_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  sched_req_type req_payload,
   output logic          rsp_valid,
   output sched_rsp_type rsp_payload,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [4:0]    csr_wdata
);

   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // control and configuration
   logic                 state_ff, state_in;
   logic                 policy_ff, policy_in;
   logic [4:0]           active_ff, active_in;
   logic [31:0]          now_ff, now_in;
   logic [MAX_TASKS-1:0] fresh_ff, fresh_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 rd_valid_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   sched_rsp_type        rsp_ff, rsp_in;

   // best candidate so far
   logic                 best_found_ff, best_found_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   logic [32:0]          best_key_ff, best_key_in;
   task_entry_type       best_ff, best_in;

   // task memory
   task_entry_type       mem [MAX_TASKS];
   task_entry_type       rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   task_entry_type       wr_data;

   logic                 accept;
   logic [CW-1:0]        count;
   logic                 scan_done;
   logic                 load_ok;
   logic [15:0]          eff_work;
   logic [31:0]          eff_rel;
   logic                 eligible;
   logic [32:0]          cand_key;
   logic                 take;
   logic [15:0]          work_dec;
   logic [32:0]          rel_sum;

   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_SCAN);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // active entry count clamped to the table depth
   always_comb begin
      if (32'(active_ff) > 32'(MAX_TASKS)) begin
         count = CW'(MAX_TASKS);
      end else begin
         count = CW'(active_ff);
      end
   end

   assign load_ok   = 32'(req_payload.task_index) < 32'(MAX_TASKS);
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < count);
   assign rd_addr   = issue_ff[AW-1:0];
   assign scan_done = (state_ff == ST_SCAN) && (issue_ff >= count) && !rd_valid_ff;

   // candidate evaluation on the registered read data
   always_comb begin
      if (fresh_ff[rd_idx_ff]) begin
         eff_work = rd_data_ff.exec_time;
         eff_rel  = '0;
      end else begin
         eff_work = rd_data_ff.work_left;
         eff_rel  = rd_data_ff.release_time;
      end
      eligible = (now_ff >= eff_rel) && (eff_work != '0);
      if (policy_ff == POLICY_EDF) begin
         cand_key = {1'b0, eff_rel} + {17'b0, rd_data_ff.rel_deadline};
      end else begin
         cand_key = {17'b0, rd_data_ff.period};
      end
      take = rd_valid_ff && eligible && (!best_found_ff || (cand_key < best_key_ff));
   end

   // write-back of the chosen entry
   assign work_dec = best_ff.work_left - 16'd1;
   assign rel_sum  = {1'b0, best_ff.release_time} + {17'b0, best_ff.period};

   // main control
   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      active_in     = active_ff;
      now_in        = now_ff;
      fresh_in      = fresh_ff;
      issue_in      = issue_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      best_in       = best_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(req_payload.task_index);
      wr_data       = '0;

      // csr transfer
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = csr_wdata[0];
            CSR_ACTIVE: active_in = csr_wdata;
            default: ;
         endcase
      end

      // scan: issue reads and keep the best candidate
      if (rd_en) begin
         issue_in = issue_ff + CW'(1);
      end
      if (take) begin
         best_found_in          = 1'b1;
         best_idx_in            = rd_idx_ff;
         best_key_in            = cand_key;
         best_in                = rd_data_ff;
         best_in.work_left      = eff_work;
         best_in.release_time   = eff_rel;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.done_kind = req_payload.req_type;
               unique case (req_payload.req_type)
                  REQ_LOAD: begin
                     rsp_valid_in = 1'b1;
                     now_in       = '0;
                     if (load_ok) begin
                        wr_en                = 1'b1;
                        wr_data.period       = req_payload.period;
                        wr_data.exec_time    = req_payload.exec_time;
                        wr_data.rel_deadline = req_payload.rel_deadline;
                        wr_data.work_left    = req_payload.exec_time;
                        wr_data.release_time = '0;
                        fresh_in[wr_addr]    = 1'b0;
                     end
                  end
                  REQ_RESTART: begin
                     rsp_valid_in = 1'b1;
                     now_in       = '0;
                     fresh_in     = '1;
                  end
                  REQ_TICK: begin
                     state_in      = ST_SCAN;
                     issue_in      = '0;
                     best_found_in = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in              = ST_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_in.done_kind      = REQ_TICK;
               rsp_in.tick_time      = now_ff;
               now_in                = (now_ff == TIME_MAX) ? now_ff : now_ff + 32'd1;
               if (best_found_ff) begin
                  rsp_in.running_task = 5'(32'(best_idx_ff) + 32'd1);
                  wr_en               = 1'b1;
                  wr_addr             = best_idx_ff;
                  wr_data             = best_ff;
                  fresh_in[best_idx_ff] = 1'b0;
                  if (work_dec == '0) begin
                     rsp_in.job_finished  = 1'b1;
                     wr_data.work_left    = best_ff.exec_time;
                     wr_data.release_time = rel_sum[32] ? TIME_MAX : rel_sum[31:0];
                  end else begin
                     wr_data.work_left    = work_dec;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // task memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POLICY_RM;
         active_ff     <= 5'd1;
         now_ff        <= '0;
         fresh_ff      <= '1;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         active_ff     <= active_in;
         now_ff        <= now_in;
         fresh_ff      <= fresh_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_en;
         rsp_valid_ff  <= rsp_valid_in;
         best_found_ff <= best_found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_addr;
      rsp_ff      <= rsp_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_ff     <= best_in;
   end

`ifndef SYNTHESIS
   // memory reads only happen while scanning
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> state_ff == ST_SCAN)
      else $error("task memory read outside scan");

   // no write-back while reads are still being issued
   a_no_write_during_reads: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("task memory write during scan reads");

   // end of scan gives a tick response and frees the block
   a_scan_done_rsp: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> rsp_valid_ff && rsp_ff.done_kind == REQ_TICK && state_ff == ST_IDLE)
      else $error("scan end without tick response");

   // only tick responses name a task, and a finished job needs a task
   a_task_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.running_task != '0 |-> rsp_ff.done_kind == REQ_TICK)
      else $error("task reported on a non-tick response");

   a_finish_needs_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.job_finished |-> rsp_ff.running_task != '0)
      else $error("job finished on an idle tick");
`endif

endmodule

// File: tb/sv/rm_edf_tick_scheduler_chk.sv
`timescale 1ns / 100ps
// checker for the rm / edf tick scheduler: tracks task state, predicts each response and compares
module rm_edf_tick_scheduler_chk
   import edfs_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  sched_req_type req_payload,
   input  logic          rsp_valid,
   input  sched_rsp_type rsp_payload,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [4:0]    csr_wdata,
   output int            mismatch_count,
   output int            decisions_due
);

   // shadow copy of the scheduler state
   logic        policy_q;
   logic [4:0]  active_q;
   logic [15:0] period_mem   [MAX_TASKS];
   logic [15:0] exec_mem     [MAX_TASKS];
   logic [15:0] deadline_mem [MAX_TASKS];
   logic [15:0] work_mem     [MAX_TASKS];
   logic [31:0] release_mem  [MAX_TASKS];
   logic [31:0] now_tick;

   // responses still owed by the block, oldest first
   sched_rsp_type decision_q [$];

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? TIME_MAX : sum[31:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // apply one request to the shadow state and work out its response
   task automatic schedule_step(input sched_req_type req, output sched_rsp_type rsp);
      int          count;
      int          best;
      int          i;
      logic [32:0] best_key;
      logic [32:0] key;
      rsp = '0;
      rsp.done_kind = req.req_type;
      case (req.req_type)
         REQ_LOAD: begin
            if (req.task_index < MAX_TASKS) begin
               period_mem[req.task_index]   = req.period;
               exec_mem[req.task_index]     = req.exec_time;
               deadline_mem[req.task_index] = req.rel_deadline;
               work_mem[req.task_index]     = req.exec_time;
               release_mem[req.task_index]  = '0;
            end
            now_tick = '0;
         end
         REQ_RESTART: begin
            for (i = 0; i < MAX_TASKS; i++) begin
               work_mem[i]    = exec_mem[i];
               release_mem[i] = '0;
            end
            now_tick = '0;
         end
         REQ_TICK: begin
            // scan released entries with work left, lowest index wins ties
            count    = (active_q > MAX_TASKS) ? MAX_TASKS : active_q;
            best     = -1;
            best_key = '0;
            for (i = 0; i < count; i++) begin
               if (now_tick >= release_mem[i] && work_mem[i] != 16'd0) begin
                  key = (policy_q == POLICY_EDF) ?
                        {1'b0, release_mem[i]} + {17'b0, deadline_mem[i]} :
                        {17'b0, period_mem[i]};
                  if (best < 0 || key < best_key) begin
                     best     = i;
                     best_key = key;
                  end
               end
            end
            rsp.tick_time = now_tick;
            if (best >= 0) begin
               rsp.running_task = 5'(best + 1);
               work_mem[best] = work_mem[best] - 16'd1;
               // job done: next release one period later, work reloads
               if (work_mem[best] == 16'd0) begin
                  release_mem[best] = sat_add(release_mem[best], {16'b0, period_mem[best]});
                  work_mem[best]    = exec_mem[best];
                  rsp.job_finished  = 1'b1;
               end
            end
            now_tick = sat_add(now_tick, 32'd1);
         end
         default: begin
         end
      endcase
   endtask

   // watch all three channels
   always @(posedge clock) begin
      sched_rsp_type want;
      int            i;
      if (reset) begin
         policy_q = POLICY_RM;
         active_q = 5'd1;
         for (i = 0; i < MAX_TASKS; i++)
            release_mem[i] = '0;
         now_tick = '0;
         decision_q.delete();
      end else begin
         // responses first: they answer earlier transfers
         if (rsp_valid) begin
            if (decision_q.size() == 0) begin
               report_mismatch($sformatf("response kind %0d with nothing due",
                                         rsp_payload.done_kind));
            end else begin
               want = decision_q.pop_front();
               if (rsp_payload.done_kind !== want.done_kind)
                  report_mismatch($sformatf("done_kind %0d, expected %0d",
                                            rsp_payload.done_kind, want.done_kind));
               if (rsp_payload.running_task !== want.running_task)
                  report_mismatch($sformatf("running_task %0d, expected %0d",
                                            rsp_payload.running_task, want.running_task));
               if (rsp_payload.tick_time !== want.tick_time)
                  report_mismatch($sformatf("tick_time %0d, expected %0d",
                                            rsp_payload.tick_time, want.tick_time));
               if (rsp_payload.job_finished !== want.job_finished)
                  report_mismatch($sformatf("job_finished %0d, expected %0d",
                                            rsp_payload.job_finished, want.job_finished));
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLICY: policy_q = csr_wdata[0];
               CSR_ACTIVE: active_q = csr_wdata;
               default: begin
               end
            endcase
         end
         // request transfer
         if (start && !busy) begin
            schedule_step(req_payload, want);
            decision_q.push_back(want);
         end
      end
      decisions_due <= decision_q.size();
   end

endmodule

// File: tb/sv/rm_edf_tick_scheduler_tb.sv
`timescale 1ns / 100ps
// testbench top for the rm / edf tick scheduler: clock, reset, stimulus and verdict
module rm_edf_tick_scheduler_tb;
   import edfs_pkg::*;

   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         PHASES          = 15;
   localparam int         ITEMS_PER_PHASE = 50;
   localparam logic [1:0] REQ_UNKNOWN     = 2'd3;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          start       = 1'b0;
   logic          busy;
   sched_req_type req_payload = '0;
   logic          rsp_valid;
   sched_rsp_type rsp_payload;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index   = CSR_POLICY;
   logic [4:0]    csr_wdata   = '0;
   int            mismatch_count;
   int            decisions_due;
   int            cycle_count = 0;
   logic          idle_en     = 1'b1;

   rm_edf_tick_scheduler DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   rm_edf_tick_scheduler_chk sched_chk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .decisions_due  (decisions_due)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic take_break();
      return idle_en && ($urandom_range(99) < 23);
   endfunction

   // mostly small values, sometimes zero, all ones or any pattern
   function automatic logic [15:0] task_field(input int small_max);
      int r;
      r = $urandom_range(99);
      if (r < 6)  return 16'd0;
      if (r < 12) return 16'hFFFF;
      if (r < 26) return 16'($urandom);
      return 16'($urandom_range(small_max, 1));
   endfunction

   function automatic sched_req_type load_req(input logic [3:0] idx);
      sched_req_type r;
      r.req_type     = REQ_LOAD;
      r.task_index   = idx;
      r.period       = task_field(40);
      r.exec_time    = task_field(6);
      r.rel_deadline = task_field(60);
      return r;
   endfunction

   // random request, ticks dominate; unused fields carry noise
   function automatic sched_req_type random_req();
      sched_req_type r;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         r = load_req(4'($urandom));
      end else begin
         r = sched_req_type'({$urandom, $urandom});
         if (pick < 86)      r.req_type = REQ_TICK;
         else if (pick < 95) r.req_type = REQ_RESTART;
         else                r.req_type = REQ_UNKNOWN;
      end
      return r;
   endfunction

   // one request transfer; start stays high afterwards
   task automatic send_request(input sched_req_type r);
      if (take_break()) begin
         start <= 1'b0;
         repeat ($urandom_range(9) == 0 ? $urandom_range(30, 4) : $urandom_range(3, 1))
            @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every owed response has arrived and the block is free
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (decisions_due != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // write both registers, idle only
   task automatic set_config(input logic policy, input logic [4:0] active);
      int i;
      for (i = 0; i < 2; i++) begin
         if (take_break()) begin
            csr_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clock);
         end
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_POLICY : CSR_ACTIVE;
         csr_wdata <= (i == 0) ? {4'b0, policy} : active;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      sched_req_type r;
      logic [4:0]    active;
      int            p;
      int            k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: load every entry so nothing is read unwritten
      set_config(POLICY_RM, 5'd16);
      for (k = 0; k < 16; k++) begin
         r.req_type     = REQ_LOAD;
         r.task_index   = 4'(k);
         r.period       = 16'(4 + k);
         r.exec_time    = 16'(1 + k % 3);
         r.rel_deadline = 16'(3 * k + 2);
         case (k)
            0: begin
               // widest values, never preferred under rm
               r.period       = 16'hFFFF;
               r.exec_time    = 16'hFFFF;
               r.rel_deadline = 16'hFFFF;
            end
            1: begin
               // zero period: released again at once
               r.period       = 16'd0;
               r.exec_time    = 16'd2;
               r.rel_deadline = 16'd0;
            end
            2: begin
               // zero execution time: never chosen
               r.period    = 16'd0;
               r.exec_time = 16'd0;
            end
            default: begin
            end
         endcase
         send_request(r);
      end
      r = sched_req_type'({$urandom, $urandom});
      r.req_type = REQ_TICK;
      repeat (3) send_request(r);
      r.req_type = REQ_RESTART;
      send_request(r);
      r.req_type = REQ_UNKNOWN;
      send_request(r);
      r = '{REQ_LOAD, 4'd15, 16'd2, 16'd1, 16'd5};
      send_request(r);
      r.req_type = REQ_TICK;
      repeat (2) send_request(r);

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         drain();
         idle_en = (p != 3);
         case (p)
            0:       active = 5'd16;
            1:       active = 5'd0;
            2:       active = 5'd31;
            3:       active = 5'd1;
            4:       active = 5'd17;
            default: active = ($urandom_range(9) < 7) ? 5'($urandom_range(16, 1))
                                                     : 5'($urandom_range(31));
         endcase
         set_config(p[0] ? POLICY_EDF : POLICY_RM, active);
         // fresh start: a restart or a burst of loads
         if ($urandom_range(1) == 0) begin
            r = sched_req_type'({$urandom, $urandom});
            r.req_type = REQ_RESTART;
            send_request(r);
         end else begin
            repeat ($urandom_range(4, 1)) send_request(load_req(4'($urandom)));
         end
         for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_request(random_req());
      end

      drain();
      idle_en = 1'b1;
      repeat (25) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
